// ===== rtl/core/ffsa_pkg.sv =====
// Package for the first-free slot allocator: sizes, codes and item types.
`default_nettype none

package ffsa_pkg;

	// Table geometry
	localparam int MAX_SLOTS  = 64;
	localparam int OWNER_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_SLOTS);
	localparam int CNT_W      = $clog2(MAX_SLOTS + 1);

	// Fixed field widths of the command and result items
	localparam int ACTION_W = 2;
	localparam int SLOT_W   = 7;
	localparam int STATUS_W = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT    = 2'd1;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_TABLE     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ARG      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL         = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

	typedef struct packed {
		logic [ACTION_W-1:0]   action;
		logic [OWNER_BITS-1:0] owner_id;
		logic [SLOT_W-1:0]     slot_number;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_W-1:0]     granted_slot;
		logic [OWNER_BITS-1:0] owner_out;
		logic                  slot_is_free;
		logic [SLOT_W-1:0]     free_slots;
		logic [SLOT_W-1:0]     occupied_slots;
	} result_t;

	// Outcome of the first-free search
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} grant_t;

	// Write port of the owner RAM
	typedef struct packed {
		logic                  en;
		logic [IDX_W-1:0]      addr;
		logic [OWNER_BITS-1:0] data;
	} ram_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/first_free_slot_allocator.sv =====
// Top level of the first-free slot allocator.
`default_nettype none

// First-free slot allocator. A command item is taken whenever start is high;
// busy never rises, so one item per clock is sustained. The item is registered
// at the edge where it is taken, worked on in the following cycle, and its
// result is registered at the end of that cycle and shown on result with done
// high for exactly one cycle. The receiver cannot stall, so every result must be
// taken as it appears. Work on an item uses the owner RAM's
// registered read, issued as the item is taken, and the combinational priority
// encoder that finds the lowest free slot among MAX_SLOTS occupancy flops.
// Owner values live in RAM; occupancy lives in flops that reset and any
// register write clear at once, so no clearing pass is needed. Configuration
// writes (cfg_ready is always high) must be made only while no item is in
// flight; writing either register empties the table.
module first_free_slot_allocator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire ffsa_pkg::cmd_t                      cmd,
	output logic                                     done,
	output ffsa_pkg::result_t                        result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ffsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ffsa_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IDX_W = ffsa_pkg::IDX_W;
	localparam int CNT_W = ffsa_pkg::CNT_W;

	logic                          accept;
	logic                          cfg_wr;
	logic                          cfg_clear;

	logic                          table_en_q;
	logic [ffsa_pkg::SLOT_W-1:0]   slot_count_q;
	logic [ffsa_pkg::MAX_SLOTS-1:0] occ_q;
	logic [CNT_W-1:0]              occ_total_q;

	logic                          valid_s1;
	ffsa_pkg::cmd_t                cmd_s1;

	logic [IDX_W-1:0]              rd_addr;
	logic [ffsa_pkg::OWNER_BITS-1:0] rd_owner;
	ffsa_pkg::ram_wr_t             ram_wr;
	ffsa_pkg::grant_t              grant;

	logic [CNT_W-1:0]              cap;
	logic [IDX_W-1:0]              idx_s1;
	logic                          slot_ok;
	logic                          cur_occ;
	logic                          occ_set;
	logic                          occ_clr;
	logic [CNT_W-1:0]              occ_total_next;
	ffsa_pkg::result_t             res_d;
	logic                          done_q;
	ffsa_pkg::result_t             result_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Configuration registers; a write to either one empties the table
	always_comb begin
		case (cfg_index)
			ffsa_pkg::CFG_TABLE_ENABLED: cfg_clear = cfg_wr;
			ffsa_pkg::CFG_SLOT_COUNT:    cfg_clear = cfg_wr;
			default:                     cfg_clear = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_en_q   <= 1'b0;
			slot_count_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				ffsa_pkg::CFG_TABLE_ENABLED: table_en_q   <= cfg_data[0];
				ffsa_pkg::CFG_SLOT_COUNT:    slot_count_q <= cfg_data[ffsa_pkg::SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective capacity: slot count saturated at the table size
	always_comb begin
		if (CNT_W'(slot_count_q) > CNT_W'(ffsa_pkg::MAX_SLOTS)) begin
			cap = CNT_W'(ffsa_pkg::MAX_SLOTS);
		end else begin
			cap = CNT_W'(slot_count_q);
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	// Owner read is issued as the item is taken (1-based slot to index)
	assign rd_addr = cmd.slot_number[IDX_W-1:0] - IDX_W'(1);

	ffsa_owner_ram u_owner_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.raddr (rd_addr),
		.rdata (rd_owner)
	);

	ffsa_first_free u_first_free (
		.occ   (occ_q),
		.cap   (cap),
		.grant (grant)
	);

	// Operation decode and result
	assign idx_s1  = cmd_s1.slot_number[IDX_W-1:0] - IDX_W'(1);
	assign slot_ok = (cmd_s1.slot_number != '0) && (CNT_W'(cmd_s1.slot_number) <= cap);
	assign cur_occ = occ_q[idx_s1];

	always_comb begin
		occ_set = 1'b0;
		occ_clr = 1'b0;
		res_d   = '0;
		if (!table_en_q) begin
			res_d.status = ffsa_pkg::ST_NO_TABLE;
		end else begin
			case (cmd_s1.action)
				ffsa_pkg::ACT_RESERVE: begin
					if (cmd_s1.owner_id == '0) begin
						res_d.status = ffsa_pkg::ST_BAD_ARG;
					end else if (grant.found) begin
						res_d.status       = ffsa_pkg::ST_OK;
						res_d.granted_slot = ffsa_pkg::SLOT_W'(grant.idx)
							+ ffsa_pkg::SLOT_W'(1);
						occ_set            = 1'b1;
					end else begin
						res_d.status = ffsa_pkg::ST_FULL;
					end
				end
				ffsa_pkg::ACT_RELEASE: begin
					if (!slot_ok) begin
						res_d.status = ffsa_pkg::ST_BAD_ARG;
					end else if (!cur_occ) begin
						res_d.status = ffsa_pkg::ST_ALREADY_FREE;
					end else begin
						res_d.status    = ffsa_pkg::ST_OK;
						res_d.owner_out = rd_owner;
						occ_clr         = 1'b1;
					end
				end
				ffsa_pkg::ACT_QUERY: begin
					if (!slot_ok) begin
						res_d.status = ffsa_pkg::ST_BAD_ARG;
					end else begin
						res_d.status       = ffsa_pkg::ST_OK;
						res_d.owner_out    = cur_occ ? rd_owner : '0;
						res_d.slot_is_free = !cur_occ;
					end
				end
				default: begin
					res_d.status = ffsa_pkg::ST_BAD_ARG;
				end
			endcase
		end

		occ_total_next = occ_total_q + CNT_W'(occ_set) - CNT_W'(occ_clr);

		if (table_en_q) begin
			res_d.occupied_slots = ffsa_pkg::SLOT_W'(occ_total_next);
			res_d.free_slots     = (cap >= occ_total_next)
				? ffsa_pkg::SLOT_W'(cap - occ_total_next) : '0;
		end
	end

	// Owner write on a successful reserve
	always_comb begin
		ram_wr.en   = valid_s1 && occ_set;
		ram_wr.addr = grant.idx;
		ram_wr.data = cmd_s1.owner_id;
	end

	// Occupancy flops and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			occ_total_q <= '0;
		end else if (cfg_clear) begin
			occ_q       <= '0;
			occ_total_q <= '0;
		end else if (valid_s1) begin
			if (occ_set) begin
				occ_q[grant.idx] <= 1'b1;
			end
			if (occ_clr) begin
				occ_q[idx_s1] <= 1'b0;
			end
			occ_total_q <= occ_total_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTH
	// Count of occupied slots tracks the occupancy flops
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		occ_total_q == CNT_W'($countones(occ_q)))
		else $error("occupied count out of step with occupancy bits");

	// Every item taken is followed by a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("item taken without a result");

	// A register write empties the table
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_clear |=> (occ_q == '0))
		else $error("register write did not clear the table");

	// A granted slot lies inside the capacity
	a_grant_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.granted_slot != '0)) |->
		(CNT_W'(result.granted_slot) <= cap))
		else $error("granted slot beyond capacity");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ffsa_owner_ram.sv =====
// Owner RAM: one write port, one registered read port with write-through bypass.
`default_nettype none

module ffsa_owner_ram (
	input  wire logic                             clk,
	input  wire ffsa_pkg::ram_wr_t                wr,
	input  wire logic [ffsa_pkg::IDX_W-1:0]       raddr,
	output logic      [ffsa_pkg::OWNER_BITS-1:0]  rdata
);

	logic [ffsa_pkg::OWNER_BITS-1:0] mem [ffsa_pkg::MAX_SLOTS];

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read; a write to the same entry at this edge is forwarded
	always_ff @(posedge clk) begin
		if (wr.en && (wr.addr == raddr)) begin
			rdata <= wr.data;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ffsa_first_free.sv =====
// First-free search: priority encoder over free slots inside the capacity.
`default_nettype none

module ffsa_first_free (
	input  wire logic [ffsa_pkg::MAX_SLOTS-1:0] occ,
	input  wire logic [ffsa_pkg::CNT_W-1:0]     cap,
	output ffsa_pkg::grant_t                    grant
);

	logic [ffsa_pkg::MAX_SLOTS-1:0] free_mask;

	// Free and within the effective capacity
	always_comb begin
		for (int i = 0; i < ffsa_pkg::MAX_SLOTS; i++) begin
			free_mask[i] = !occ[i] && (ffsa_pkg::CNT_W'(i) < cap);
		end
	end

	// Lowest set bit wins
	always_comb begin
		grant.found = |free_mask;
		grant.idx   = '0;
		for (int i = ffsa_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
			if (free_mask[i]) begin
				grant.idx = ffsa_pkg::IDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire
